### sv/priority_interrupt_vector_allocator_defines.svh
// assertion macros for the priority interrupt vector allocator
// included by priority_interrupt_vector_allocator.sv, no other dependencies
`ifndef PRIORITY_INTERRUPT_VECTOR_ALLOCATOR_DEFINES_SVH
`define PRIORITY_INTERRUPT_VECTOR_ALLOCATOR_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PIVA_ASSERT_IMPL(label, clk_sig, rstn_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |-> (cons)) \
        else $error("piva: same-cycle check failed");

// next-cycle implication, checked outside reset
`define PIVA_ASSERT_NEXT(label, clk_sig, rstn_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |=> (cons)) \
        else $error("piva: next-cycle check failed");

`endif

### sv/piva_pkg.sv
// package for the priority interrupt vector allocator
// vector range, level limits, request kinds, status codes, sequencer states
package piva_pkg;

    localparam int VEC_MIN      = 64;
    localparam int VEC_MAX      = 207;
    localparam int LOW_LEVEL    = 5;
    localparam int CLOCK_LVL    = 13;
    localparam int TOP_LEVEL    = 15;
    localparam int OFFSET_COUNT = 15;
    localparam int MSG_DEPTH    = VEC_MAX - VEC_MIN + 1;
    localparam int MSG_IDX_W    = $clog2(MSG_DEPTH);

    localparam int AFF_W = 64;
    localparam int VEC_W = 8;
    localparam int LVL_W = 4;
    localparam int STS_W = 3;

    typedef enum logic [1:0] {
        KIND_ALLOC = 2'd0,
        KIND_FREE  = 2'd1,
        KIND_CLAIM = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    typedef enum logic [STS_W-1:0] {
        ST_OK        = 3'd0,
        ST_BAD_LEVEL = 3'd1,
        ST_NONE_FREE = 3'd2,
        ST_RANGE     = 3'd3,
        ST_NOT_ALLOC = 3'd4,
        ST_USED      = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_EVAL = 3'b100
    } state_t;

endpackage

### sv/priority_interrupt_vector_allocator.sv
// priority interrupt vector allocator: top level with search sequencer and vector tables
// depends on piva_pkg and priority_interrupt_vector_allocator_defines.svh
//
// channel  | dir | handshake         | payload
// s        | in  | s_tvalid/s_tready | tuser: kind; tdata: desired_level, vector_in
// m        | out | m_tvalid/m_tready | tdata: status, vector_out, level_out, affinity_out
// cfg      | in  | cfg_we            | cfg_wdata: default_affinity
//
// one table read and one evaluation per step, S_READ then S_EVAL; each item starts in S_IDLE
// free, claim, ignored kinds, bad levels and clock level or above finish at the first
// evaluation; allocate examines one candidate per step, up to 15 offsets x 8 levels
// both tables are flop vectors cleared by reset, so no clearing pass is needed
// a new item is taken while a finished result waits; a stalled output holds the
// sequencer at its last step until the result register frees up
`include "priority_interrupt_vector_allocator_defines.svh"

module priority_interrupt_vector_allocator
    import piva_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [15:0]  s_tdata,   // desired_level[3:0], vector_in[11:4], zero[15:12]
    input  logic [1:0]   s_tuser,   // kind[1:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [79:0]  m_tdata,   // status[2:0], vector_out[10:3], level_out[14:11],
                                    // affinity_out[78:15], zero[79]
    input  logic         cfg_we,
    input  logic [63:0]  cfg_wdata
);

    state_t                 state_reg, state_next;
    kind_t                  kind_reg, kind_next;
    logic [LVL_W-1:0]       desired_reg, desired_next;
    logic [VEC_W-1:0]       vec_reg, vec_next;
    logic [LVL_W-1:0]       lvl_reg, lvl_next;
    logic [3:0]             off_reg, off_next;
    logic                   used_rd_reg, used_rd_next;
    logic                   msg_rd_reg, msg_rd_next;
    logic                   range_rd_reg, range_rd_next;
    logic [255:0]           general_used_reg, general_used_next;
    logic [MSG_DEPTH-1:0]   msg_alloc_reg, msg_alloc_next;
    logic [AFF_W-1:0]       affinity_reg, affinity_next;
    logic                   m_valid_reg, m_valid_next;
    status_t                status_out_reg, status_out_next;
    logic [VEC_W-1:0]       vec_out_reg, vec_out_next;
    logic [LVL_W-1:0]       lvl_out_reg, lvl_out_next;
    logic [AFF_W-1:0]       aff_out_reg, aff_out_next;

    logic [VEC_W-1:0]       rd_addr;
    logic [VEC_W-1:0]       rd_diff;
    logic                   rd_in_range;
    logic [MSG_IDX_W-1:0]   msg_idx;
    logic                   out_free;
    logic                   finish;
    logic                   set_used, clr_used, set_msg, clr_msg;
    status_t                res_status;
    logic [VEC_W-1:0]       res_vec;
    logic [LVL_W-1:0]       res_lvl;
    logic [AFF_W-1:0]       res_aff;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, aff_out_reg, lvl_out_reg, vec_out_reg, status_out_reg};

    // candidate vector is level*16+offset for allocate
    assign rd_addr     = (kind_reg == KIND_ALLOC) ? {lvl_reg, off_reg} : vec_reg;
    assign rd_in_range = (rd_addr >= VEC_W'(VEC_MIN)) && (rd_addr <= VEC_W'(VEC_MAX));
    assign rd_diff     = rd_addr - VEC_W'(VEC_MIN);
    assign msg_idx     = rd_in_range ? rd_diff[MSG_IDX_W-1:0] : '0;
    assign out_free    = !m_valid_reg || m_tready;

    always_comb
    begin
        state_next        = state_reg;
        kind_next         = kind_reg;
        desired_next      = desired_reg;
        vec_next          = vec_reg;
        lvl_next          = lvl_reg;
        off_next          = off_reg;
        used_rd_next      = used_rd_reg;
        msg_rd_next       = msg_rd_reg;
        range_rd_next     = range_rd_reg;
        general_used_next = general_used_reg;
        msg_alloc_next    = msg_alloc_reg;
        affinity_next     = cfg_we ? cfg_wdata : affinity_reg;
        m_valid_next      = (m_valid_reg && m_tready) ? 1'b0 : m_valid_reg;
        status_out_next   = status_out_reg;
        vec_out_next      = vec_out_reg;
        lvl_out_next      = lvl_out_reg;
        aff_out_next      = aff_out_reg;

        finish     = 1'b0;
        set_used   = 1'b0;
        clr_used   = 1'b0;
        set_msg    = 1'b0;
        clr_msg    = 1'b0;
        res_status = ST_OK;
        res_vec    = '0;
        res_lvl    = '0;
        res_aff    = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    kind_next    = kind_t'(s_tuser);
                    desired_next = s_tdata[3:0];
                    vec_next     = s_tdata[11:4];
                    lvl_next     = s_tdata[3:0];
                    off_next     = '0;
                    state_next   = S_READ;
                end
            end
            S_READ:
            begin
                used_rd_next  = general_used_reg[rd_addr];
                msg_rd_next   = rd_in_range ? msg_alloc_reg[msg_idx] : 1'b0;
                range_rd_next = rd_in_range;
                state_next    = S_EVAL;
            end
            S_EVAL:
            begin
                case (kind_reg)
                    KIND_ALLOC:
                    begin
                        if (desired_reg < LVL_W'(LOW_LEVEL) || desired_reg >= LVL_W'(TOP_LEVEL))
                        begin
                            finish     = 1'b1;
                            res_status = ST_BAD_LEVEL;
                        end
                        else if (desired_reg >= LVL_W'(CLOCK_LVL))
                        begin
                            finish     = 1'b1;
                            res_status = ST_NONE_FREE;
                        end
                        else if (range_rd_reg && !used_rd_reg && !msg_rd_reg)
                        begin
                            finish     = 1'b1;
                            set_used   = 1'b1;
                            set_msg    = 1'b1;
                            res_status = ST_OK;
                            res_vec    = rd_addr;
                            res_lvl    = lvl_reg;
                            res_aff    = affinity_reg;
                        end
                        else if (lvl_reg > LVL_W'(LOW_LEVEL))
                        begin
                            lvl_next   = lvl_reg - LVL_W'(1);
                            state_next = S_READ;
                        end
                        else if (off_reg < 4'(OFFSET_COUNT - 1))
                        begin
                            off_next   = off_reg + 4'd1;
                            lvl_next   = desired_reg;
                            state_next = S_READ;
                        end
                        else
                        begin
                            finish     = 1'b1;
                            res_status = ST_NONE_FREE;
                        end
                    end
                    KIND_FREE:
                    begin
                        finish = 1'b1;
                        if (!range_rd_reg)
                        begin
                            res_status = ST_RANGE;
                        end
                        else if (!msg_rd_reg)
                        begin
                            res_status = ST_NOT_ALLOC;
                        end
                        else
                        begin
                            clr_used   = 1'b1;
                            clr_msg    = 1'b1;
                            res_status = ST_OK;
                        end
                    end
                    KIND_CLAIM:
                    begin
                        finish = 1'b1;
                        if (used_rd_reg)
                        begin
                            res_status = ST_USED;
                        end
                        else
                        begin
                            set_used   = 1'b1;
                            res_status = ST_OK;
                        end
                    end
                    default:
                    begin
                        finish     = 1'b1;
                        res_status = ST_OK;
                    end
                endcase

                // a finished item waits here until the result register is free
                if (finish)
                begin
                    if (out_free)
                    begin
                        if (set_used)
                        begin
                            general_used_next[rd_addr] = 1'b1;
                        end
                        if (clr_used)
                        begin
                            general_used_next[rd_addr] = 1'b0;
                        end
                        if (set_msg)
                        begin
                            msg_alloc_next[msg_idx] = 1'b1;
                        end
                        if (clr_msg)
                        begin
                            msg_alloc_next[msg_idx] = 1'b0;
                        end
                        m_valid_next    = 1'b1;
                        status_out_next = res_status;
                        vec_out_next    = res_vec;
                        lvl_out_next    = res_lvl;
                        aff_out_next    = res_aff;
                        state_next      = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_EVAL;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            general_used_reg <= '0;
            msg_alloc_reg    <= '0;
            affinity_reg     <= AFF_W'(1);
            m_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            general_used_reg <= general_used_next;
            msg_alloc_reg    <= msg_alloc_next;
            affinity_reg     <= affinity_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        desired_reg    <= desired_next;
        vec_reg        <= vec_next;
        lvl_reg        <= lvl_next;
        off_reg        <= off_next;
        used_rd_reg    <= used_rd_next;
        msg_rd_reg     <= msg_rd_next;
        range_rd_reg   <= range_rd_next;
        status_out_reg <= status_out_next;
        vec_out_reg    <= vec_out_next;
        lvl_out_reg    <= lvl_out_next;
        aff_out_reg    <= aff_out_next;
    end

    // a vector held as a message vector is always marked used in the general table
    `PIVA_ASSERT_IMPL(a_msg_implies_used, clk, rst_n, 1'b1,
        (msg_alloc_reg & general_used_reg[VEC_MAX:VEC_MIN]) == msg_alloc_reg)

    // a new result only ever comes out of the evaluation step
    `PIVA_ASSERT_IMPL(a_result_from_eval, clk, rst_n, $rose(m_valid_reg),
        $past(state_reg == S_EVAL))

    // an allocated vector sits at its reported level
    `PIVA_ASSERT_IMPL(a_level_matches, clk, rst_n, m_valid_reg && (lvl_out_reg != '0),
        vec_out_reg[7:4] == lvl_out_reg)

    // the search never steps beyond the last offset
    `PIVA_ASSERT_NEXT(a_offset_bound, clk, rst_n, state_reg == S_EVAL && kind_reg == KIND_ALLOC,
        off_reg < 4'(OFFSET_COUNT))

endmodule

### verif/priority_interrupt_vector_allocator_test.sv
`timescale 1ns / 100ps
// testbench for priority_interrupt_vector_allocator: directed and random requests on the
// input stream, every result checked against a scoreboard that tracks both vector tables
// depends on piva_pkg and the allocator top level
module priority_interrupt_vector_allocator_test
    import piva_pkg::*;
;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int HOLD_CYCLES = 700;

    typedef struct packed {
        logic [AFF_W-1:0] affinity;
        logic [LVL_W-1:0] level;
        logic [VEC_W-1:0] vector;
        status_t          status;
    } vector_grant_t;

    class vector_table_scoreboard;
        bit               general_used [256];
        bit               msg_allocated [MSG_DEPTH];
        logic [AFF_W-1:0] affinity;
        vector_grant_t    grants_due [$];
        int               mismatches;
        int               checked;

        function new();
            affinity   = 64'd1;
            mismatches = 0;
            checked    = 0;
            foreach (general_used[i])
                general_used[i] = 1'b0;
            foreach (msg_allocated[i])
                msg_allocated[i] = 1'b0;
        endfunction

        function vector_grant_t predict_grant(kind_t kind, logic [3:0] lvl, logic [7:0] vec);
            vector_grant_t r;
            int            off;
            int            l;
            int            cand;
            bit            found;
            r        = '0;
            r.status = ST_OK;
            found    = 1'b0;
            case (kind)
                KIND_ALLOC:
                begin
                    if (int'(lvl) < LOW_LEVEL || int'(lvl) >= TOP_LEVEL)
                        r.status = ST_BAD_LEVEL;
                    else
                    begin
                        r.status = ST_NONE_FREE;
                        for (off = 0; off < OFFSET_COUNT && !found; off++)
                        begin
                            for (l = int'(lvl); l >= LOW_LEVEL && l < CLOCK_LVL && !found; l--)
                            begin
                                cand = l * 16 + off;
                                if (cand >= VEC_MIN && cand <= VEC_MAX &&
                                    !general_used[cand] && !msg_allocated[cand - VEC_MIN])
                                begin
                                    msg_allocated[cand - VEC_MIN] = 1'b1;
                                    general_used[cand]            = 1'b1;
                                    r.status   = ST_OK;
                                    r.vector   = 8'(cand);
                                    r.level    = 4'(l);
                                    r.affinity = affinity;
                                    found      = 1'b1;
                                end
                            end
                        end
                    end
                end
                KIND_FREE:
                begin
                    if (int'(vec) < VEC_MIN || int'(vec) > VEC_MAX)
                        r.status = ST_RANGE;
                    else if (!msg_allocated[int'(vec) - VEC_MIN])
                        r.status = ST_NOT_ALLOC;
                    else
                    begin
                        msg_allocated[int'(vec) - VEC_MIN] = 1'b0;
                        general_used[vec]                  = 1'b0;
                    end
                end
                KIND_CLAIM:
                begin
                    if (general_used[vec])
                        r.status = ST_USED;
                    else
                        general_used[vec] = 1'b1;
                end
                default:
                    r.status = ST_OK;
            endcase
            return r;
        endfunction

        function void note_request(kind_t kind, logic [3:0] lvl, logic [7:0] vec);
            grants_due.push_back(predict_grant(kind, lvl, vec));
        endfunction

        function void check_result(logic [79:0] data);
            vector_grant_t got;
            vector_grant_t want;
            got = data[78:0];
            if (grants_due.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected result: status %0d vector %0d level %0d affinity %h",
                             got.status, got.vector, got.level, got.affinity);
                mismatches++;
            end
            else
            begin
                want = grants_due.pop_front();
                if (got.status !== want.status || got.vector !== want.vector ||
                    got.level !== want.level || got.affinity !== want.affinity)
                begin
                    if (mismatches < 10)
                        $display({"mismatch on result %0d: exp status %0d vector %0d level %0d ",
                                  "affinity %h, got status %0d vector %0d level %0d affinity %h"},
                                 checked, want.status, want.vector, want.level, want.affinity,
                                 got.status, got.vector, got.level, got.affinity);
                    mismatches++;
                end
            end
            checked++;
        endfunction

        function bit pick_allocated(output logic [7:0] vec);
            int count;
            int k;
            count = 0;
            vec   = '0;
            foreach (msg_allocated[i])
                count += msg_allocated[i];
            if (count == 0)
                return 1'b0;
            k = $urandom_range(count - 1);
            foreach (msg_allocated[i])
            begin
                if (msg_allocated[i])
                begin
                    if (k == 0)
                        vec = 8'(i + VEC_MIN);
                    k--;
                end
            end
            return 1'b1;
        endfunction
    endclass

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic [15:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = '0;
    logic        m_tready  = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [63:0] cfg_wdata = '0;
    wire         s_tready;
    wire         m_tvalid;
    wire  [79:0] m_tdata;

    vector_table_scoreboard sb = new();

    int tx_idle_pct = 14;
    int rx_idle_pct = 80;
    int phase       = 0;
    bit rx_hold     = 1'b0;
    int cycle_count = 0;

    priority_interrupt_vector_allocator DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rx_hold)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    // long output stall so the block backs up into its input
    initial
    begin
        wait (phase == 3);
        repeat (40) @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    task automatic send_request(input kind_t kind, input logic [3:0] lvl, input logic [7:0] vec);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {4'b0000, vec, lvl};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_request(kind, lvl, vec);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (sb.grants_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_affinity(input logic [63:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        sb.affinity = value;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_random(input int count);
        int         done;
        int         pick;
        kind_t      kind;
        logic [3:0] lvl;
        logic [7:0] vec;
        logic [7:0] held;
        done = 0;
        while (done < count)
        begin
            pick = $urandom_range(99);
            lvl  = 4'($urandom_range(15));
            vec  = 8'($urandom_range(255));
            if (pick < 45)
            begin
                kind = KIND_ALLOC;
                if ($urandom_range(9) < 8)
                    lvl = 4'($urandom_range(CLOCK_LVL - 1, LOW_LEVEL));
            end
            else if (pick < 75)
            begin
                kind = KIND_FREE;
                if ($urandom_range(9) < 8 && sb.pick_allocated(held))
                    vec = held;
            end
            else if (pick < 85)
            begin
                kind = KIND_CLAIM;
                if ($urandom_range(1) == 0)
                    vec = 8'($urandom_range(VEC_MAX, VEC_MIN));
            end
            else if (pick < 90)
                kind = KIND_NONE;
            else
                kind = kind_t'($urandom_range(3));
            send_request(kind, lvl, vec);
            done++;
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        phase = 1;
        tx_idle_pct = 14;
        rx_idle_pct = 80;
        // levels outside the span, at clock level or above, and at both ends of the span
        send_request(KIND_ALLOC, 4'd0, 8'd255);
        send_request(KIND_ALLOC, 4'd4, 8'd0);
        send_request(KIND_ALLOC, 4'd15, 8'd255);
        send_request(KIND_ALLOC, 4'd13, 8'd0);
        send_request(KIND_ALLOC, 4'd14, 8'd0);
        send_request(KIND_ALLOC, 4'd12, 8'd0);
        send_request(KIND_ALLOC, 4'd5, 8'd0);
        // claims, including one already used, then an allocate at the lowest level
        send_request(KIND_CLAIM, 4'd15, 8'd81);
        send_request(KIND_CLAIM, 4'd0, 8'd0);
        send_request(KIND_CLAIM, 4'd0, 8'd255);
        send_request(KIND_CLAIM, 4'd15, 8'd0);
        send_request(KIND_ALLOC, 4'd5, 8'd255);
        // frees: allocated, twice, out of range, never allocated, claimed only
        send_request(KIND_FREE, 4'd0, 8'd80);
        send_request(KIND_FREE, 4'd15, 8'd80);
        send_request(KIND_FREE, 4'd0, 8'd63);
        send_request(KIND_FREE, 4'd0, 8'd208);
        send_request(KIND_FREE, 4'd0, 8'd0);
        send_request(KIND_FREE, 4'd0, 8'd255);
        send_request(KIND_FREE, 4'd0, 8'd64);
        send_request(KIND_FREE, 4'd0, 8'd207);
        send_request(KIND_FREE, 4'd0, 8'd81);
        send_request(KIND_CLAIM, 4'd0, 8'd192);
        send_request(KIND_NONE, 4'd15, 8'd255);
        send_request(KIND_ALLOC, 4'd7, 8'd255);
        send_request(KIND_FREE, 4'd15, 8'd192);
        drain_results();

        write_affinity(64'hFFFF_FFFF_FFFF_FFFF);
        send_random(550);
        drain_results();

        tx_idle_pct = 80;
        rx_idle_pct = 14;
        write_affinity(64'd0);
        send_random(550);
        drain_results();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_affinity({32'($urandom), 32'($urandom)});
        phase = 3;
        send_random(275);
        drain_results();
        send_random(275);
        drain_results();
        repeat (20) @(posedge clk);

        if (sb.mismatches == 0 && sb.grants_due.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

### priority_interrupt_vector_allocator.f
+incdir+sv
sv/piva_pkg.sv
sv/priority_interrupt_vector_allocator.sv
verif/priority_interrupt_vector_allocator_test.sv
